// File: src/prr_pkg.sv
`timescale 1ns / 1ps
// Package for the polyphase rational resampler: default sizes, field widths,
// operation and register codes, and the command and status structs that join
// the controller to the datapath. No dependencies.
package prr_pkg;

    // Defaults for the top-level parameters.
    localparam int TAPS_DEF        = 16;
    localparam int MAX_PHASES_DEF  = 512;
    localparam int MAX_BURST_DEF   = 8;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF   = 18;

    // Fixed field widths.
    localparam int OP_W       = 2;
    localparam int COEF_IDX_W = 13;
    localparam int FACTOR_W   = 10;
    localparam int CFG_IDX_W  = 2;

    // Factor arithmetic runs one bit wider so that phase plus step fits.
    localparam int DIV_W    = FACTOR_W + 1;
    localparam int MAX_DOWN = 512;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE  = 2'd0,
        OP_COEF    = 2'd1,
        OP_RESTART = 2'd2
    } t_op;

    localparam logic [CFG_IDX_W-1:0] REG_UP_FACTOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_FACTOR = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CNT_GO,
        ST_CNT_WAIT,
        ST_SUM,
        ST_END_GO,
        ST_END_WAIT,
        ST_MAC_GO,
        ST_MAC_WAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic cfg_wr;
        logic restart;
        logic shift_in;
        logic coef_wr;
        logic sun_dec;
        logic run_load;
        logic div_start;
        logic div_sel_end;
        logic cnt_take;
        logic sum_calc;
        logic end_take;
        logic mac_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic sun_zero;
        logic div_done;
        logic mac_done;
        logic out_free;
        logic last;
    } t_sts;

endpackage

// File: src/prr_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by the phase tracker.
// Self-contained; no package needed.
module prr_div #(
    parameter int W = 11
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_rem;
    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          fits;

    always_comb begin
        shifted = {r_rem, r_quo[W-1]};
        fits    = shifted >= {1'b0, i_den};
        diff    = shifted - {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], fits};
            r_rem <= fits ? diff[W-1:0] : shifted[W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// File: src/prr_datapath.sv
`timescale 1ns / 1ps
// Datapath: factor registers, phase tracker, delay line, coefficient bank,
// serial multiply-accumulate and output register. Uses prr_pkg and prr_div.
module prr_datapath #(
    parameter int TAPS        = prr_pkg::TAPS_DEF,
    parameter int MAX_PHASES  = prr_pkg::MAX_PHASES_DEF,
    parameter int MAX_BURST   = prr_pkg::MAX_BURST_DEF,
    parameter int SAMPLE_BITS = prr_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = prr_pkg::COEF_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  prr_pkg::t_cmd                      i_cmd,
    output prr_pkg::t_sts                      o_sts,
    input  logic [prr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [prr_pkg::FACTOR_W-1:0]       i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample_in,
    input  logic [prr_pkg::COEF_IDX_W-1:0]     i_coef_index,
    input  logic signed [COEF_BITS-1:0]        i_coef_value,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out,
    output logic                               o_last_of_run,
    output logic                               o_clipped,
    output logic                               o_burst_overflow
);

    localparam int FW         = prr_pkg::FACTOR_W;
    localparam int DW         = prr_pkg::DIV_W;
    localparam int IW         = prr_pkg::COEF_IDX_W;
    localparam int BANK_DEPTH = MAX_PHASES * TAPS;
    localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int PROD_W     = FW + $clog2(TAPS) + 1;
    localparam int MC_W       = $clog2(TAPS + 2);
    localparam int LEFT_W     = $clog2(MAX_BURST + 1);
    localparam int MUL_W      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W      = MUL_W + $clog2(TAPS) + 1;

    localparam logic signed [ACC_W-1:0] RND    = ACC_W'(64'sd1 <<< (COEF_BITS - 2));
    localparam logic signed [ACC_W-1:0] SAT_HI =
        ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    function automatic logic [DW-1:0] clamp_factor(input logic [FW-1:0] v,
                                                   input logic [DW-1:0] hi);
        logic [DW-1:0] r;
        if (v == '0) begin
            r = DW'(1);
        end else if (DW'(v) > hi) begin
            r = hi;
        end else begin
            r = DW'(v);
        end
        return r;
    endfunction

    // Factors, stored already clamped.
    logic [DW-1:0] r_up;
    logic [DW-1:0] r_down;

    // Stream position.
    logic [FW-1:0] r_phase;
    logic [FW-1:0] r_sun;
    logic [FW-1:0] r_run_phase;
    logic [DW-1:0] r_count;
    logic [DW-1:0] r_sum;
    logic [LEFT_W-1:0] r_left;
    logic          r_ovf;

    logic signed [SAMPLE_BITS-1:0] r_dly [TAPS];
    logic signed [COEF_BITS-1:0]   r_bank [BANK_DEPTH];
    logic signed [COEF_BITS-1:0]   r_coef;
    logic signed [SAMPLE_BITS-1:0] r_samp;
    logic signed [MUL_W-1:0]       r_prod;
    logic signed [ACC_W-1:0]       r_acc;

    logic            r_mac_busy;
    logic [MC_W-1:0] r_mac_cnt;
    logic            r_v1;
    logic            r_v2;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample_out;
    logic                          r_last;
    logic                          r_clip;
    logic                          r_ovf_out;

    logic                  cfg_hit;
    logic [IW+ADDR_W-1:0]  wr_ext;
    logic                  wr_in_range;
    logic [PROD_W-1:0]     rd_full;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  issue;
    logic                  mac_done;
    logic [DW-1:0]         div_num;
    logic [DW-1:0]         div_den;
    logic                  div_done;
    logic [DW-1:0]         div_quo;
    logic [DW-1:0]         div_rem;
    logic [DW-1:0]         cnt_new;
    logic [2*DW-1:0]       step_prod;
    logic signed [ACC_W-1:0] rounded;
    logic signed [ACC_W-1:0] shifted;
    logic signed [SAMPLE_BITS-1:0] sat_val;
    logic                  sat_clip;

    assign cfg_hit = i_cmd.cfg_wr &&
                     (i_cfg_index == prr_pkg::REG_UP_FACTOR ||
                      i_cfg_index == prr_pkg::REG_DOWN_FACTOR);

    always_comb begin
        wr_ext      = {{ADDR_W{1'b0}}, i_coef_index};
        wr_in_range = wr_ext < (IW + ADDR_W)'(BANK_DEPTH);
    end

    // Taps are read oldest sample first: tap k of the window meets
    // coefficient TAPS-1-k of the branch.
    always_comb begin
        rd_full = PROD_W'(r_run_phase) * PROD_W'(TAPS) + PROD_W'(TAPS - 1)
                  - PROD_W'(r_mac_cnt);
        rd_addr = rd_full[ADDR_W-1:0];
        issue   = r_mac_busy && (r_mac_cnt < MC_W'(TAPS));
        mac_done = r_mac_busy && (r_mac_cnt == MC_W'(TAPS + 1));
    end

    // Count of outputs in this run is (L-1-p)/M + 1; the end of the run is
    // (p + count*M) split by L into a sample step and the next phase.
    always_comb begin
        div_num   = i_cmd.div_sel_end ? r_sum : (r_up - DW'(1) - DW'(r_phase));
        div_den   = i_cmd.div_sel_end ? r_up : r_down;
        cnt_new   = div_quo + DW'(1);
        step_prod = r_count * r_down;
    end

    prr_div #(
        .W (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_comb begin
        rounded  = r_acc + RND;
        shifted  = rounded >>> (COEF_BITS - 1);
        sat_clip = 1'b0;
        if (shifted > SAT_HI) begin
            sat_val  = SAT_HI[SAMPLE_BITS-1:0];
            sat_clip = 1'b1;
        end else if (shifted < SAT_LO) begin
            sat_val  = SAT_LO[SAMPLE_BITS-1:0];
            sat_clip = 1'b1;
        end else begin
            sat_val = shifted[SAMPLE_BITS-1:0];
        end
    end

    // Control and stream state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up        <= DW'(1);
            r_down      <= DW'(1);
            r_phase     <= '0;
            r_sun       <= FW'(TAPS - 1);
            r_left      <= '0;
            r_ovf       <= 1'b0;
            r_mac_busy  <= 1'b0;
            r_mac_cnt   <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < TAPS; i++) begin
                r_dly[i] <= '0;
            end
        end else begin
            if (i_cmd.cfg_wr && i_cfg_index == prr_pkg::REG_UP_FACTOR) begin
                r_up <= clamp_factor(i_cfg_data, DW'(MAX_PHASES));
            end
            if (i_cmd.cfg_wr && i_cfg_index == prr_pkg::REG_DOWN_FACTOR) begin
                r_down <= clamp_factor(i_cfg_data, DW'(prr_pkg::MAX_DOWN));
            end

            if (cfg_hit || i_cmd.restart) begin
                r_phase <= '0;
                r_sun   <= FW'(TAPS - 1);
                for (int i = 0; i < TAPS; i++) begin
                    r_dly[i] <= '0;
                end
            end else begin
                if (i_cmd.shift_in) begin
                    for (int i = 0; i < TAPS - 1; i++) begin
                        r_dly[i] <= r_dly[i+1];
                    end
                    r_dly[TAPS-1] <= i_sample_in;
                end else if (issue) begin
                    // Rotate so that every tap passes the read point once and
                    // the line is back in order after the last one.
                    for (int i = 0; i < TAPS - 1; i++) begin
                        r_dly[i] <= r_dly[i+1];
                    end
                    r_dly[TAPS-1] <= r_dly[0];
                end
                if (i_cmd.sun_dec) begin
                    r_sun <= r_sun - FW'(1);
                end
                if (i_cmd.end_take) begin
                    r_phase <= div_rem[FW-1:0];
                    r_sun   <= FW'(div_quo - DW'(1));
                end
            end

            if (i_cmd.cnt_take) begin
                r_ovf  <= cnt_new > DW'(MAX_BURST);
                r_left <= (cnt_new > DW'(MAX_BURST)) ? LEFT_W'(MAX_BURST)
                                                      : LEFT_W'(cnt_new);
            end else if (i_cmd.out_load) begin
                r_left <= r_left - LEFT_W'(1);
            end

            if (i_cmd.mac_start) begin
                r_mac_busy <= 1'b1;
                r_mac_cnt  <= '0;
            end else if (r_mac_busy) begin
                r_mac_cnt <= r_mac_cnt + MC_W'(1);
                if (mac_done) begin
                    r_mac_busy <= 1'b0;
                end
            end
            r_v1 <= issue;
            r_v2 <= r_v1;

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers without reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_take) begin
            r_count <= cnt_new;
        end
        if (i_cmd.sum_calc) begin
            r_sum <= DW'(r_phase) + step_prod[DW-1:0];
        end
        if (i_cmd.run_load) begin
            r_run_phase <= r_phase;
        end else if (i_cmd.out_load) begin
            r_run_phase <= r_run_phase + r_down[FW-1:0];
        end
        if (issue) begin
            r_samp <= r_dly[0];
        end
        if (r_v1) begin
            r_prod <= r_samp * r_coef;
        end
        if (i_cmd.mac_start) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.out_load) begin
            r_sample_out <= sat_val;
            r_clip       <= sat_clip;
            r_last       <= (r_left == LEFT_W'(1));
            r_ovf_out    <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_wr && wr_in_range) begin
            r_bank[wr_ext[ADDR_W-1:0]] <= i_coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef <= r_bank[rd_addr];
    end

    always_comb begin
        o_sts.sun_zero = (r_sun == '0);
        o_sts.div_done = div_done;
        o_sts.mac_done = mac_done;
        o_sts.out_free = !r_out_valid || i_out_ready;
        o_sts.last     = (r_left == LEFT_W'(1));
    end

    assign o_out_valid      = r_out_valid;
    assign o_sample_out     = r_sample_out;
    assign o_last_of_run    = r_last;
    assign o_clipped        = r_clip;
    assign o_burst_overflow = r_ovf_out;

endmodule

// File: src/prr_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: takes items and register writes, sequences the
// run length division, the step division and one filter pass per output.
// Uses prr_pkg.
module prr_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [prr_pkg::OP_W-1:0]      i_operation,
    input  logic                          i_cfg_valid,
    input  prr_pkg::t_sts                 i_sts,
    output logic                          o_in_ready,
    output logic                          o_cfg_ready,
    output prr_pkg::t_cmd                 o_cmd
);

    prr_pkg::t_state r_state;
    prr_pkg::t_state n_state;
    logic            in_take;

    assign in_take = (r_state == prr_pkg::ST_IDLE) && i_in_valid && !i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prr_pkg::ST_IDLE: begin
                if (in_take && prr_pkg::t_op'(i_operation) == prr_pkg::OP_SAMPLE
                    && i_sts.sun_zero) begin
                    n_state = prr_pkg::ST_CNT_GO;
                end
            end
            prr_pkg::ST_CNT_GO:   n_state = prr_pkg::ST_CNT_WAIT;
            prr_pkg::ST_CNT_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = prr_pkg::ST_SUM;
                end
            end
            prr_pkg::ST_SUM:      n_state = prr_pkg::ST_END_GO;
            prr_pkg::ST_END_GO:   n_state = prr_pkg::ST_END_WAIT;
            prr_pkg::ST_END_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = prr_pkg::ST_MAC_GO;
                end
            end
            prr_pkg::ST_MAC_GO:   n_state = prr_pkg::ST_MAC_WAIT;
            prr_pkg::ST_MAC_WAIT: begin
                if (i_sts.mac_done) begin
                    n_state = prr_pkg::ST_EMIT;
                end
            end
            prr_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.last ? prr_pkg::ST_IDLE : prr_pkg::ST_MAC_GO;
                end
            end
            default: n_state = prr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        unique case (r_state)
            prr_pkg::ST_IDLE: begin
                o_cfg_ready   = 1'b1;
                o_in_ready    = !i_cfg_valid;
                o_cmd.cfg_wr  = i_cfg_valid;
                if (in_take) begin
                    unique case (prr_pkg::t_op'(i_operation))
                        prr_pkg::OP_SAMPLE: begin
                            o_cmd.shift_in = 1'b1;
                            o_cmd.sun_dec  = !i_sts.sun_zero;
                            o_cmd.run_load = i_sts.sun_zero;
                        end
                        prr_pkg::OP_COEF:    o_cmd.coef_wr = 1'b1;
                        prr_pkg::OP_RESTART: o_cmd.restart = 1'b1;
                        default: ;
                    endcase
                end
            end
            prr_pkg::ST_CNT_GO:   o_cmd.div_start = 1'b1;
            prr_pkg::ST_CNT_WAIT: o_cmd.cnt_take  = i_sts.div_done;
            prr_pkg::ST_SUM:      o_cmd.sum_calc  = 1'b1;
            prr_pkg::ST_END_GO: begin
                o_cmd.div_start   = 1'b1;
                o_cmd.div_sel_end = 1'b1;
            end
            // The divider reads its divisor on every step, so the selection holds.
            prr_pkg::ST_END_WAIT: begin
                o_cmd.div_sel_end = 1'b1;
                o_cmd.end_take    = i_sts.div_done;
            end
            prr_pkg::ST_MAC_GO:   o_cmd.mac_start = 1'b1;
            prr_pkg::ST_MAC_WAIT: ;
            prr_pkg::ST_EMIT:     o_cmd.out_load  = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

// File: src/polyphase_rational_resampler_top.sv
`timescale 1ns / 1ps
// Top level of the polyphase rational resampler: controller plus datapath.
// Uses prr_pkg, prr_ctrl and prr_datapath.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    operation, sample, coef index and value
//   out      output     o_out_valid / i_out_ready  sample_out, last, clipped, overflow
//   cfg      input      i_cfg_valid / o_cfg_ready  register index, 10-bit data
//
// Coefficient writes, restarts and samples that do not complete a window leave
// the machine idle. A sample that completes a window runs two divisions for the
// phase tracker, then one pass of the single multiply-accumulate over the
// coefficient bank read port per result. Reset restarts the stream and sets
// both factors to one; the bank keeps no reset. A stalled output holds the
// machine in its emit state.
module polyphase_rational_resampler_top #(
    parameter int TAPS        = prr_pkg::TAPS_DEF,
    parameter int MAX_PHASES  = prr_pkg::MAX_PHASES_DEF,
    parameter int MAX_BURST   = prr_pkg::MAX_BURST_DEF,
    parameter int SAMPLE_BITS = prr_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = prr_pkg::COEF_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [prr_pkg::OP_W-1:0]           i_operation,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample_in,
    input  logic [prr_pkg::COEF_IDX_W-1:0]     i_coef_index,
    input  logic signed [COEF_BITS-1:0]        i_coef_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out,
    output logic                               o_last_of_run,
    output logic                               o_clipped,
    output logic                               o_burst_overflow,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [prr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [prr_pkg::FACTOR_W-1:0]       i_cfg_data
);

    prr_pkg::t_cmd cmd;
    prr_pkg::t_sts sts;

    prr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_cfg_valid (i_cfg_valid),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    prr_datapath #(
        .TAPS        (TAPS),
        .MAX_PHASES  (MAX_PHASES),
        .MAX_BURST   (MAX_BURST),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_sample_in      (i_sample_in),
        .i_coef_index     (i_coef_index),
        .i_coef_value     (i_coef_value),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_sample_out     (o_sample_out),
        .o_last_of_run    (o_last_of_run),
        .o_clipped        (o_clipped),
        .o_burst_overflow (o_burst_overflow)
    );

endmodule

// File: src/prr_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the resampler top level, bound onto it below.
// Uses prr_pkg for field widths.
module prr_checker #(
    parameter int SAMPLE_BITS = prr_pkg::SAMPLE_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [prr_pkg::OP_W-1:0]      i_operation,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [SAMPLE_BITS-1:0]        o_sample_out,
    input logic                          o_clipped,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready
);

    localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // A waiting result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample_out))
        else $error("result changed while stalled");

    // Items are only taken while register writes could be taken too.
    a_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> o_cfg_ready)
        else $error("item taken outside the idle state");

    // An item that is not a sample never starts a filter run.
    a_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_operation != prr_pkg::OP_SAMPLE
        |=> o_cfg_ready)
        else $error("non-sample item left the block busy");

    // A saturated result sits at one of the two limits.
    a_clip_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clipped |-> o_sample_out == OUT_MAX || o_sample_out == OUT_MIN)
        else $error("clipped result not at a limit");

endmodule

bind polyphase_rational_resampler_top prr_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_prr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_operation  (i_operation),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_sample_out (o_sample_out),
    .o_clipped    (o_clipped),
    .i_cfg_valid  (i_cfg_valid),
    .o_cfg_ready  (o_cfg_ready)
);

// File: bench/tb_polyphase_rational_resampler_top.sv
`timescale 1ns / 1ps
// Self-checking bench for polyphase_rational_resampler_top: queued stimulus, a clocked
// driver and monitor, and an in-bench fixed-point resampler that predicts every output.
// Depends on prr_pkg and the resampler RTL only.
module tb_polyphase_rational_resampler_top;

    localparam int TAPS        = prr_pkg::TAPS_DEF;
    localparam int MAX_PHASES  = prr_pkg::MAX_PHASES_DEF;
    localparam int MAX_BURST   = prr_pkg::MAX_BURST_DEF;
    localparam int SAMPLE_BITS = prr_pkg::SAMPLE_BITS_DEF;
    localparam int COEF_BITS   = prr_pkg::COEF_BITS_DEF;
    localparam int OP_W        = prr_pkg::OP_W;
    localparam int COEF_IDX_W  = prr_pkg::COEF_IDX_W;
    localparam int CFG_IDX_W   = prr_pkg::CFG_IDX_W;
    localparam int FACTOR_W    = prr_pkg::FACTOR_W;
    localparam int MAX_DOWN    = prr_pkg::MAX_DOWN;
    localparam int BANK_SIZE   = MAX_PHASES * TAPS;

    localparam int SETTLE_CYCLES  = 256;
    localparam int TAIL_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [OP_W-1:0]      OP_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic [SAMPLE_BITS-1:0] SMP_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMP_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [COEF_BITS-1:0]   COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic [COEF_BITS-1:0]   COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS-1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef enum logic [1:0] {
        JOB_ITEM,
        JOB_CFG,
        JOB_DRAIN
    } t_job_kind;

    typedef struct packed {
        t_job_kind               kind;
        logic [OP_W-1:0]         op;
        logic [SAMPLE_BITS-1:0]  smp;
        logic [COEF_IDX_W-1:0]   cidx;
        logic [COEF_BITS-1:0]    cval;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [FACTOR_W-1:0]     reg_data;
    } t_stim;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic                   last;
        logic                   clip;
        logic                   ovf;
    } t_resample;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_in_valid   = 1'b0;
    logic                    o_in_ready;
    logic [OP_W-1:0]         i_operation  = '0;
    logic [SAMPLE_BITS-1:0]  i_sample_in  = '0;
    logic [COEF_IDX_W-1:0]   i_coef_index = '0;
    logic [COEF_BITS-1:0]    i_coef_value = '0;
    logic                    o_out_valid;
    logic                    i_out_ready  = 1'b0;
    logic [SAMPLE_BITS-1:0]  o_sample_out;
    logic                    o_last_of_run;
    logic                    o_clipped;
    logic                    o_burst_overflow;
    logic                    i_cfg_valid  = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index  = '0;
    logic [FACTOR_W-1:0]     i_cfg_data   = '0;

    // Stimulus waiting to be sent and outputs waiting to be seen.
    t_stim     pending_items[$];
    t_resample expected_samples[$];

    // Resampler state as the bench sees it.
    logic [SAMPLE_BITS-1:0] history[TAPS];
    logic [COEF_BITS-1:0]   bank[BANK_SIZE];
    logic [FACTOR_W-1:0]    up_reg;
    logic [FACTOR_W-1:0]    down_reg;
    int unsigned            next_branch;
    int unsigned            samples_to_go;

    // Entries that the stimulus has already defined, so that no unwritten one is read.
    bit          coef_planned[BANK_SIZE];

    bit          in_taken;
    bit          cfg_taken;
    int unsigned gap_left;
    int unsigned in_calm;
    int unsigned quiet_cycles;
    int unsigned calm_left;
    int unsigned stall_left;
    int unsigned idle_cycles;
    int unsigned mismatch_count;

    polyphase_rational_resampler_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_sample_in      (i_sample_in),
        .i_coef_index     (i_coef_index),
        .i_coef_value     (i_coef_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_sample_out     (o_sample_out),
        .o_last_of_run    (o_last_of_run),
        .o_clipped        (o_clipped),
        .o_burst_overflow (o_burst_overflow),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_factor(logic [FACTOR_W-1:0] v, int unsigned hi);
        if (v == 0) begin
            return 1;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic int unsigned gcd(int unsigned a, int unsigned b);
        int unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // ---------------- prediction ----------------

    task automatic restart_stream();
        for (int k = 0; k < TAPS; k++) begin
            history[k] = '0;
        end
        next_branch   = 0;
        samples_to_go = TAPS - 1;
    endtask

    task automatic write_factor(logic [CFG_IDX_W-1:0] idx, logic [FACTOR_W-1:0] data);
        if (idx == prr_pkg::REG_UP_FACTOR) begin
            up_reg = data;
            restart_stream();
        end else if (idx == prr_pkg::REG_DOWN_FACTOR) begin
            down_reg = data;
            restart_stream();
        end
    endtask

    // The branch taps run in reverse against the window, oldest sample first.
    function automatic t_resample filter_branch(int unsigned branch);
        longint    acc;
        longint    r;
        t_resample res;
        acc = 0;
        for (int k = 0; k < TAPS; k++) begin
            acc += longint'($signed(history[k]))
                 * longint'($signed(bank[branch*TAPS + TAPS-1-k]));
        end
        acc += longint'(1) <<< (COEF_BITS-2);
        r = acc >>> (COEF_BITS-1);
        res = '0;
        if (r > SAT_HI) begin
            r = SAT_HI;
            res.clip = 1'b1;
        end
        if (r < SAT_LO) begin
            r = SAT_LO;
            res.clip = 1'b1;
        end
        res.value = r[SAMPLE_BITS-1:0];
        return res;
    endfunction

    task automatic resample_item(logic [OP_W-1:0] op, logic [SAMPLE_BITS-1:0] smp,
                                 logic [COEF_IDX_W-1:0] cidx, logic [COEF_BITS-1:0] cval);
        int unsigned lf;
        int unsigned mf;
        int unsigned total;
        int unsigned adv;
        bit          dropped;
        t_resample   burst[$];
        t_resample   one;
        if (op == prr_pkg::OP_COEF) begin
            if (cidx < BANK_SIZE) begin
                bank[cidx] = cval;
            end
            return;
        end
        if (op == prr_pkg::OP_RESTART) begin
            restart_stream();
            return;
        end
        if (op != prr_pkg::OP_SAMPLE) begin
            return;
        end
        for (int k = 0; k < TAPS-1; k++) begin
            history[k] = history[k+1];
        end
        history[TAPS-1] = smp;
        if (samples_to_go > 0) begin
            samples_to_go--;
            return;
        end
        lf = clamp_factor(up_reg, MAX_PHASES);
        mf = clamp_factor(down_reg, MAX_DOWN);
        if (next_branch >= lf) begin
            next_branch = next_branch % lf;
        end
        dropped = 1'b0;
        // Outputs past the burst limit are lost, but the phase still moves past them.
        do begin
            if (burst.size() < MAX_BURST) begin
                burst.push_back(filter_branch(next_branch));
            end else begin
                dropped = 1'b1;
            end
            total       = next_branch + mf;
            adv         = total / lf;
            next_branch = total % lf;
        end while (adv == 0);
        samples_to_go = adv - 1;
        foreach (burst[i]) begin
            one      = burst[i];
            one.ovf  = dropped;
            one.last = (i == burst.size() - 1);
            expected_samples.push_back(one);
        end
    endtask

    task automatic check_output();
        t_resample want;
        if (expected_samples.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: output %0d arrived with nothing expected", $realtime,
                         $signed(o_sample_out));
            end
            return;
        end
        want = expected_samples.pop_front();
        if (o_sample_out !== want.value || o_last_of_run !== want.last
            || o_clipped !== want.clip || o_burst_overflow !== want.ovf) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: sample exp %0d got %0d, last exp %b got %b,", $realtime,
                         $signed(want.value), $signed(o_sample_out),
                         want.last, o_last_of_run);
                $display("    clip exp %b got %b, overflow exp %b got %b",
                         want.clip, o_clipped, want.ovf, o_burst_overflow);
            end
        end
    endtask

    // ---------------- stimulus building ----------------

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            return SMP_MAX;
        end
        if (pick < 10) begin
            return SMP_MIN;
        end
        return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
    endfunction

    // Mostly small coefficients so that not every output saturates.
    function automatic logic [COEF_BITS-1:0] rand_coef();
        int unsigned pick;
        int          s;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            return COEF_MAX;
        end
        if (pick < 8) begin
            return COEF_MIN;
        end
        if (pick < 13) begin
            return COEF_BITS'($urandom_range(0, (1 << COEF_BITS) - 1));
        end
        s = int'($urandom_range(0, 32767)) - 16384;
        return s[COEF_BITS-1:0];
    endfunction

    function automatic logic [COEF_IDX_W-1:0] rand_index();
        return COEF_IDX_W'($urandom_range(0, BANK_SIZE-1));
    endfunction

    task automatic add_item(logic [OP_W-1:0] op, logic [SAMPLE_BITS-1:0] smp,
                            logic [COEF_IDX_W-1:0] cidx, logic [COEF_BITS-1:0] cval);
        t_stim s;
        s          = '0;
        s.kind     = JOB_ITEM;
        s.op       = op;
        s.smp      = smp;
        s.cidx     = cidx;
        s.cval     = cval;
        s.reg_idx  = REG_SPARE_A;
        pending_items.push_back(s);
    endtask

    task automatic add_sample(logic [SAMPLE_BITS-1:0] smp);
        add_item(prr_pkg::OP_SAMPLE, smp, rand_index(), rand_coef());
    endtask

    task automatic add_coef(int unsigned idx, logic [COEF_BITS-1:0] val);
        coef_planned[idx] = 1'b1;
        add_item(prr_pkg::OP_COEF, rand_sample(), COEF_IDX_W'(idx), val);
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [FACTOR_W-1:0] data);
        t_stim s;
        s          = '0;
        s.kind     = JOB_CFG;
        s.op       = prr_pkg::OP_SAMPLE;
        s.reg_idx  = idx;
        s.reg_data = data;
        pending_items.push_back(s);
    endtask

    task automatic add_drain();
        t_stim s;
        s      = '0;
        s.kind = JOB_DRAIN;
        s.op   = prr_pkg::OP_SAMPLE;
        pending_items.push_back(s);
    endtask

    // Fill every branch that the phase can reach from zero: the multiples of gcd(L, M).
    task automatic load_branches(int unsigned lf, int unsigned mf);
        int unsigned g;
        int unsigned idx;
        g = gcd(lf, mf);
        for (int unsigned b = 0; b < lf; b += g) begin
            for (int t = 0; t < TAPS; t++) begin
                idx = b*TAPS + t;
                if (!coef_planned[idx]) begin
                    add_coef(idx, rand_coef());
                end
            end
        end
    endtask

    task automatic add_random_item();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 86) begin
            add_sample(rand_sample());
        end else if (pick < 94) begin
            add_coef($urandom_range(0, BANK_SIZE-1), rand_coef());
        end else if (pick < 97) begin
            add_item(prr_pkg::OP_RESTART, rand_sample(), rand_index(), rand_coef());
        end else begin
            add_item(OP_UNUSED, rand_sample(), rand_index(), rand_coef());
        end
    endtask

    task automatic run_phase(logic [FACTOR_W-1:0] up, logic [FACTOR_W-1:0] dn,
                             int unsigned count);
        add_cfg(prr_pkg::REG_UP_FACTOR, up);
        add_cfg(prr_pkg::REG_DOWN_FACTOR, dn);
        load_branches(clamp_factor(up, MAX_PHASES), clamp_factor(dn, MAX_DOWN));
        for (int unsigned i = 0; i < count; i++) begin
            if (i == count / 2) begin
                add_drain();
            end
            add_random_item();
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned pick;
        if (in_calm != 0) begin
            in_calm--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            in_calm = $urandom_range(20, 80);
            return 0;
        end
        if (pick < 55) begin
            return 0;
        end
        if (pick < 92) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(12, 60);
    endfunction

    // ---------------- driver ----------------

    always @(negedge i_clk) begin : feed_proc
        logic  in_v;
        logic  cfg_v;
        t_stim nxt;
        in_v  = i_in_valid;
        cfg_v = i_cfg_valid;
        if (in_taken) begin
            in_v     = 1'b0;
            in_taken = 1'b0;
        end
        if (cfg_taken) begin
            cfg_v     = 1'b0;
            cfg_taken = 1'b0;
        end
        if (expected_samples.size() != 0) begin
            quiet_cycles = 0;
        end else if (quiet_cycles < SETTLE_CYCLES) begin
            quiet_cycles++;
        end
        if (i_rst_n && !in_v && !cfg_v && pending_items.size() != 0) begin
            nxt = pending_items[0];
            case (nxt.kind)
                JOB_ITEM: begin
                    if (gap_left != 0) begin
                        gap_left--;
                    end else begin
                        i_operation  <= nxt.op;
                        i_sample_in  <= nxt.smp;
                        i_coef_index <= nxt.cidx;
                        i_coef_value <= nxt.cval;
                        in_v = 1'b1;
                        pending_items.delete(0);
                        gap_left = pick_gap();
                    end
                end
                // A sample with no output may still be in flight, so let the block settle.
                JOB_CFG: begin
                    if (quiet_cycles >= SETTLE_CYCLES) begin
                        i_cfg_index <= nxt.reg_idx;
                        i_cfg_data  <= nxt.reg_data;
                        cfg_v = 1'b1;
                        pending_items.delete(0);
                    end
                end
                default: begin
                    if (expected_samples.size() == 0) begin
                        pending_items.delete(0);
                    end
                end
            endcase
        end
        i_in_valid  <= in_v;
        i_cfg_valid <= cfg_v;
    end

    always @(negedge i_clk) begin : sink_proc
        int unsigned pick;
        if (calm_left != 0) begin
            calm_left--;
            i_out_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                calm_left = $urandom_range(40, 200);
            end else if (pick < 20) begin
                stall_left = $urandom_range(1, 3);
            end else if (pick < 23) begin
                stall_left = $urandom_range(15, 70);
            end
        end
    end

    // ---------------- monitor and watchdog ----------------

    always @(posedge i_clk) begin : watch_proc
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            // Outputs are checked before a new item adds its expectations.
            if (o_out_valid && i_out_ready) begin
                check_output();
                moved = 1'b1;
            end
            if (i_in_valid && o_in_ready) begin
                resample_item(i_operation, i_sample_in, i_coef_index, i_coef_value);
                in_taken     = 1'b1;
                quiet_cycles = 0;
                moved        = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                write_factor(i_cfg_index, i_cfg_data);
                cfg_taken = 1'b1;
                moved     = 1'b1;
            end
            if (moved) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin : main_proc
        up_reg   = FACTOR_W'(1);
        down_reg = FACTOR_W'(1);
        restart_stream();

        // Branch zero with the largest tap on the newest sample and the most negative
        // on the oldest, so that full-scale runs saturate both ways.
        for (int t = 0; t < TAPS; t++) begin
            if (t == 0) begin
                add_coef(t, COEF_MAX);
            end else if (t == TAPS-1) begin
                add_coef(t, COEF_MIN);
            end else begin
                add_coef(t, rand_coef());
            end
        end
        add_item(OP_UNUSED, SMP_MAX, COEF_IDX_W'(BANK_SIZE-1), COEF_MAX);
        add_sample(SMP_MAX);
        add_sample(SMP_MIN);
        add_sample('0);
        for (int i = 0; i < TAPS-3; i++) begin
            add_sample(rand_sample());
        end
        for (int i = 0; i < 3; i++) begin
            add_sample(SMP_MAX);
        end
        for (int i = 0; i < 3; i++) begin
            add_sample(SMP_MIN);
        end
        add_item(prr_pkg::OP_RESTART, SMP_MIN, '0, '0);
        add_sample(SMP_MAX);
        add_coef(BANK_SIZE-1, '1);
        add_coef(BANK_SIZE/2, '0);

        // Factor settings, extremes included: zero acts as one and 1023 clamps to 512.
        // Nine branches with a step of one overrun the burst limit.
        run_phase(10'd0, 10'd0, 20);
        run_phase(10'd3, 10'd2, 25);
        add_cfg(REG_SPARE_A, FACTOR_W'($urandom_range(0, 1023)));
        run_phase(10'd2, 10'd3, 20);
        run_phase(10'd512, 10'd256, 20);
        add_cfg(REG_SPARE_B, FACTOR_W'($urandom_range(0, 1023)));
        run_phase(10'd1023, 10'd1023, 20);
        run_phase(10'd9, 10'd1, 25);
        run_phase(10'd5, 10'd1, 25);
        run_phase(10'd1, 10'd5, 25);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid || i_cfg_valid) begin
            @(posedge i_clk);
        end
        while (expected_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_samples.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
